// ===== rtl/core/sfp_pkg.sv =====
`timescale 1ns / 1ps

package sfp_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 6;
    localparam int IDX_W           = 6;
    localparam int ERR_W           = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int DEF_MAX_PAYLOAD = 32;

    // beats ahead of the payload: sync, sync, id, device, length
    localparam int HDR_BEATS = 5;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clr_sum;
        logic add_sum;
        logic ld_id;
        logic ld_dev;
        logic ld_len;
        logic wr_payload;
        logic err;
        logic emit_start;
        logic emitting;
    } sfp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic len_bad;
        logic len_zero;
        logic data_last;
        logic sum_ok;
        logic emit_last;
    } sfp_stat_t;

endpackage

// ===== rtl/core/sfp_ctrl.sv =====
`timescale 1ns / 1ps

module sfp_ctrl
    import sfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  sfp_stat_t stat,
    output sfp_cmd_t  cmd
);

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_SYNC1 = 3'd1;
    localparam logic [2:0] ST_SYNC2 = 3'd2;
    localparam logic [2:0] ST_ID    = 3'd3;
    localparam logic [2:0] ST_DEV   = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_CHECK = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_stall = (state_reg == ST_EMIT);
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (in_fire && stat.sync1_hit)
                begin
                    state_next = ST_SYNC1;
                end
            end
            ST_SYNC1:
            begin
                if (in_fire)
                begin
                    if (stat.sync2_hit)
                    begin
                        cmd.clr_sum = 1'b1;
                        state_next  = ST_SYNC2;
                    end
                    else
                    begin
                        cmd.err    = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_SYNC2:
            begin
                if (in_fire)
                begin
                    cmd.ld_id   = 1'b1;
                    cmd.add_sum = 1'b1;
                    state_next  = ST_ID;
                end
            end
            ST_ID:
            begin
                if (in_fire)
                begin
                    cmd.ld_dev  = 1'b1;
                    cmd.add_sum = 1'b1;
                    state_next  = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (in_fire)
                begin
                    cmd.add_sum = 1'b1;
                    if (stat.len_bad)
                    begin
                        cmd.err    = 1'b1;
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.ld_len = 1'b1;
                        state_next = stat.len_zero ? ST_CHECK : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.wr_payload = 1'b1;
                    cmd.add_sum    = 1'b1;
                    if (stat.data_last)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_fire)
                begin
                    if (stat.sum_ok)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        cmd.err    = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.emitting = 1'b1;
                if (stat.emit_last)
                begin
                    state_next = ST_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/sfp_dpath.sv =====
`timescale 1ns / 1ps

module sfp_dpath
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]    in_byte,
    input  sfp_cmd_t             cmd,
    output sfp_stat_t            stat,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    frame_byte,
    output logic                 frame_last,
    output logic [ERR_W-1:0]     errors_seen
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] first_sync_reg;
    logic [BYTE_W-1:0] second_sync_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] msg_id_reg;
    logic [BYTE_W-1:0] dev_id_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  count_reg;
    logic [ERR_W-1:0]  err_cnt_reg;

    logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] mem_q_reg;
    logic [AW-1:0]     rd_addr;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  pay_idx;
    logic              ld_out;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_is_last;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [ERR_W-1:0]  out_err_reg;

    // status towards the controller
    assign stat.sync1_hit = (in_byte == first_sync_reg);
    assign stat.sync2_hit = (in_byte == second_sync_reg);
    assign stat.len_bad   = (in_byte > BYTE_W'(MAX_PAYLOAD));
    assign stat.len_zero  = (in_byte == '0);
    assign stat.data_last = (({1'b0, count_reg} + (LEN_W+1)'(1)) >= {1'b0, len_reg});
    assign stat.sum_ok    = (in_byte == sum_reg);
    assign stat.emit_last = ld_out && emit_is_last;

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.clr_sum)
        begin
            sum_next = '0;
        end
        else if (cmd.add_sum)
        begin
            sum_next = sum_reg + in_byte;
        end
    end

    // emission sequencer: read address runs one beat ahead of the output
    assign ld_out       = cmd.emitting && (!out_valid_reg || !out_stall);
    assign last_idx     = len_reg + IDX_W'(HDR_BEATS);
    assign emit_is_last = (idx_reg == last_idx);
    assign pay_idx      = idx_next - IDX_W'(HDR_BEATS);
    assign rd_addr      = pay_idx[AW-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.emit_start)
        begin
            idx_next = '0;
        end
        else if (ld_out)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        priority if (emit_is_last)
        begin
            emit_byte = sum_reg;
        end
        else if (idx_reg == IDX_W'(0))
        begin
            emit_byte = first_sync_reg;
        end
        else if (idx_reg == IDX_W'(1))
        begin
            emit_byte = second_sync_reg;
        end
        else if (idx_reg == IDX_W'(2))
        begin
            emit_byte = msg_id_reg;
        end
        else if (idx_reg == IDX_W'(3))
        begin
            emit_byte = dev_id_reg;
        end
        else if (idx_reg == IDX_W'(4))
        begin
            emit_byte = BYTE_W'(len_reg);
        end
        else
        begin
            emit_byte = mem_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= FIRST_SYNC_RST;
            second_sync_reg <= SECOND_SYNC_RST;
            sum_reg         <= '0;
            msg_id_reg      <= '0;
            dev_id_reg      <= '0;
            len_reg         <= '0;
            count_reg       <= '0;
            err_cnt_reg     <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_FIRST_SYNC)
                begin
                    first_sync_reg <= cfg_data;
                end
                else
                begin
                    second_sync_reg <= cfg_data;
                end
            end
            sum_reg <= sum_next;
            if (cmd.ld_id)
            begin
                msg_id_reg <= in_byte;
            end
            if (cmd.ld_dev)
            begin
                dev_id_reg <= in_byte;
            end
            if (cmd.ld_len)
            begin
                len_reg   <= in_byte[LEN_W-1:0];
                count_reg <= '0;
            end
            else if (cmd.wr_payload)
            begin
                count_reg <= count_reg + LEN_W'(1);
            end
            if (cmd.err && (err_cnt_reg != '1))
            begin
                err_cnt_reg <= err_cnt_reg + ERR_W'(1);
            end
            idx_reg <= idx_next;
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload store and output beat, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.wr_payload)
        begin
            payload_mem[count_reg[AW-1:0]] <= in_byte;
        end
        mem_q_reg <= payload_mem[rd_addr];
        if (ld_out)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_is_last;
            out_err_reg  <= err_cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = out_byte_reg;
    assign frame_last  = out_last_reg;
    assign errors_seen = out_err_reg;

`ifndef ASSERT_OFF
    a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (err_cnt_reg >= $past(err_cnt_reg)))
        else $error("error count went down");

    a_err_quiet_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emitting |=> $stable(err_cnt_reg))
        else $error("error count moved during frame emission");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emitting |-> (idx_reg <= last_idx))
        else $error("emission index past end of frame");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emitting |-> (len_reg <= LEN_W'(MAX_PAYLOAD)))
        else $error("stored length above payload limit");
`endif

endmodule

// ===== rtl/core/sync_frame_parser_with_checksum.sv =====
`timescale 1ns / 1ps

// Sync / length / checksum frame parser.
// Input channel (in_valid, in_stall, in_byte): one received byte per beat.
// The parser hunts for the first sync byte, expects the second right after,
// then takes message id, device id, length and that many payload bytes,
// keeping a modulo-256 sum over id, device, length and payload.
// Output channel (out_valid, out_stall, frame_byte, frame_last, errors_seen):
// once a beat matching the sum arrives, the whole frame (sync, sync, id,
// device, length, payload, checksum) goes out, one byte per beat, with
// frame_last set on the checksum byte. errors_seen carries the saturating
// count of bad second sync, oversize length and bad checksum events.
// Throughput: one byte per cycle while parsing. Once the checksum beat is taken,
// the frame beats pass through the output register; a frame of N payload bytes
// is 6 + N bytes and drains slower if out_stall is held. in_stall is high for
// the whole drain, set by the controller; the last beat may still
// wait in the output register while new bytes are already being taken.
// Reset: parser hunting, sum, counters and error count cleared, sync bytes
// 0xAA and 0x55, output empty. Sync bytes are written on the cfg port.
module sync_frame_parser_with_checksum
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    in_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    frame_byte,
    output logic                 frame_last,
    output logic [ERR_W-1:0]     errors_seen
);

    sfp_cmd_t  cmd;
    sfp_stat_t stat;

    // phase tracking and command issue
    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // header fields, payload store, checksum, error count and output beat
    sfp_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_byte     (in_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last),
        .errors_seen (errors_seen)
    );

endmodule
